/* rtl/core/assert_macros.svh */
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/blr_pkg.sv */
package blr_pkg;

  // Input item command codes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  // Extra bits of the reciprocal used for the dot-to-byte split
  localparam int unsigned DivGuardBits = 4;

endpackage

/* rtl/core/bresenham_line_rasterizer_core.sv */
// Channel  | Handshake             | Payload
// ---------+-----------------------+---------------------------------------------------
// in       | in_valid_i/in_ready_o | opcode_i, first_x_i, first_y_i, second_x_i, second_y_i
// out      | out_valid_o/out_ready_i | dot_x_o, dot_y_o, byte_column_o, bit_in_byte_o, last_dot_o
//
// One item per cycle while in_ready_o is high: a load or a step is finished in the cycle it is accepted.
// A step on an active line writes its dot into the output register, seen the next cycle.
// Load items and steps while idle give no dot; a load replaces any line in progress.
// in_ready_o is high whenever the output register is empty or is drained in that cycle.
// rst_ni clears the line state and the output register valid flag asynchronously.

`include "assert_macros.svh"

module bresenham_line_rasterizer_core
  import blr_pkg::*;
#(
  parameter int unsigned COORD_BITS    = 11,
  parameter int unsigned DOTS_PER_BYTE = 6,
  localparam int unsigned BYTE_W = $clog2(((2 ** COORD_BITS) - 1) / DOTS_PER_BYTE + 1),
  localparam int unsigned BIT_W  = (DOTS_PER_BYTE > 1) ? $clog2(DOTS_PER_BYTE) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   opcode_i,
  input  logic [COORD_BITS-1:0]  first_x_i,
  input  logic [COORD_BITS-1:0]  first_y_i,
  input  logic [COORD_BITS-1:0]  second_x_i,
  input  logic [COORD_BITS-1:0]  second_y_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [COORD_BITS-1:0]  dot_x_o,
  output logic [COORD_BITS-1:0]  dot_y_o,
  output logic [BYTE_W-1:0]      byte_column_o,
  output logic [BIT_W-1:0]       bit_in_byte_o,
  output logic                   last_dot_o
);

  localparam int unsigned ERR_W   = COORD_BITS + 2;
  localparam int unsigned STEP_W  = COORD_BITS + 1;
  localparam int unsigned DIV_SH  = COORD_BITS + DivGuardBits;
  localparam int unsigned PROD_W  = COORD_BITS + DIV_SH;
  localparam int unsigned REM_W   = COORD_BITS + DivGuardBits;
  localparam int unsigned DIV_MUL = (2 ** DIV_SH) / DOTS_PER_BYTE;
  localparam logic signed [ERR_W-1:0] ERR_MAX = ERR_W'(2 ** COORD_BITS);
  localparam logic signed [ERR_W-1:0] ERR_MIN = -ERR_MAX;

  // Line state
  logic                         line_active_q, line_active_d;
  logic [COORD_BITS-1:0]        cur_x_q, cur_x_d;
  logic [COORD_BITS-1:0]        cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0]        dots_left_q, dots_left_d;
  logic [COORD_BITS-1:0]        minor_delta_q, minor_delta_d;
  logic signed [ERR_W-1:0]      error_acc_q, error_acc_d;
  logic [STEP_W-1:0]            error_step_q, error_step_d;
  logic signed [1:0]            y_dir_q, y_dir_d;
  logic                         x_step_q, x_step_d;
  logic                         x_is_major_q, x_is_major_d;

  // Output register
  logic                         out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0]        dot_x_q;
  logic [COORD_BITS-1:0]        dot_y_q;
  logic [BYTE_W-1:0]            byte_column_q;
  logic [BIT_W-1:0]             bit_in_byte_q;
  logic                         last_dot_q;

  logic in_fire;
  logic is_load;
  logic emit;
  logic is_last;

  // Accept whenever the output register can take a dot this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_load    = (op_e'(opcode_i) == OP_LOAD);
  assign emit       = in_fire && !is_load && line_active_q;
  assign is_last    = (dots_left_q == '0);

  // Load setup: order endpoints by x, then derive deltas and error terms
  logic                  swap_ends;
  logic [COORD_BITS-1:0] ax, ay, bx, by;
  logic [COORD_BITS-1:0] dx, ady;
  logic                  dy_neg;
  logic                  ld_x_major;
  logic [COORD_BITS-1:0] ld_major, ld_minor;

  always_comb begin
    swap_ends  = first_x_i > second_x_i;
    ax         = swap_ends ? second_x_i : first_x_i;
    ay         = swap_ends ? second_y_i : first_y_i;
    bx         = swap_ends ? first_x_i  : second_x_i;
    by         = swap_ends ? first_y_i  : second_y_i;
    dx         = bx - ax;
    dy_neg     = ay > by;
    ady        = dy_neg ? (ay - by) : (by - ay);
    ld_x_major = ady <= dx;
    ld_major   = ld_x_major ? dx  : ady;
    ld_minor   = ld_x_major ? ady : dx;
  end

  // Step along y by the stored direction, wrapping at the coordinate range
  logic [COORD_BITS-1:0] moved_y;
  assign moved_y = cur_y_q + {{(COORD_BITS - 2){y_dir_q[1]}}, y_dir_q};

  // Next line state
  always_comb begin
    line_active_d = line_active_q;
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    dots_left_d   = dots_left_q;
    minor_delta_d = minor_delta_q;
    error_acc_d   = error_acc_q;
    error_step_d  = error_step_q;
    y_dir_d       = y_dir_q;
    x_step_d      = x_step_q;
    x_is_major_d  = x_is_major_q;
    if (in_fire && is_load) begin
      line_active_d = 1'b1;
      cur_x_d       = ax;
      cur_y_d       = ay;
      dots_left_d   = ld_major;
      minor_delta_d = ld_minor;
      error_acc_d   = {3'b000, ld_major[COORD_BITS-1:1]} - {2'b00, ld_minor};
      error_step_d  = {1'b0, ld_major} - {1'b0, ld_minor};
      y_dir_d       = (ay == by) ? 2'sb00 : (dy_neg ? 2'sb11 : 2'sb01);
      x_step_d      = (dx != '0);
      x_is_major_d  = ld_x_major;
    end else if (emit) begin
      if (is_last) begin
        line_active_d = 1'b0;
      end else begin
        dots_left_d = dots_left_q - 1'b1;
        if (error_acc_q[ERR_W-1]) begin
          cur_x_d     = cur_x_q + COORD_BITS'(x_step_q);
          cur_y_d     = moved_y;
          error_acc_d = error_acc_q + {1'b0, error_step_q};
        end else begin
          if (x_is_major_q) begin
            cur_x_d = cur_x_q + 1'b1;
          end else begin
            cur_y_d = moved_y;
          end
          error_acc_d = error_acc_q - {2'b00, minor_delta_q};
        end
      end
    end
  end

  // Split the dot's y coordinate into byte column and bit by reciprocal multiply
  logic [PROD_W-1:0]     recip_prod;
  logic [COORD_BITS-1:0] quo_est;
  logic [REM_W-1:0]      rem_est;
  logic [COORD_BITS-1:0] quo_fix;
  logic [REM_W-1:0]      rem_fix;

  always_comb begin
    recip_prod = PROD_W'(cur_y_q) * PROD_W'(DIV_MUL);
    quo_est    = recip_prod[PROD_W-1 -: COORD_BITS];
    rem_est    = REM_W'(cur_y_q) - REM_W'(quo_est) * REM_W'(DOTS_PER_BYTE);
    if (rem_est >= REM_W'(DOTS_PER_BYTE)) begin
      quo_fix = quo_est + 1'b1;
      rem_fix = rem_est - REM_W'(DOTS_PER_BYTE);
    end else begin
      quo_fix = quo_est;
      rem_fix = rem_est;
    end
  end

  // Output valid: drop on drain, set when a dot is written
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  // Control and line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_active_q <= 1'b0;
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      dots_left_q   <= '0;
      minor_delta_q <= '0;
      error_acc_q   <= '0;
      error_step_q  <= '0;
      y_dir_q       <= '0;
      x_step_q      <= 1'b0;
      x_is_major_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      line_active_q <= line_active_d;
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      dots_left_q   <= dots_left_d;
      minor_delta_q <= minor_delta_d;
      error_acc_q   <= error_acc_d;
      error_step_q  <= error_step_d;
      y_dir_q       <= y_dir_d;
      x_step_q      <= x_step_d;
      x_is_major_q  <= x_is_major_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Capture the dot payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      dot_x_q       <= cur_x_q;
      dot_y_q       <= cur_y_q;
      byte_column_q <= BYTE_W'(quo_fix);
      bit_in_byte_q <= BIT_W'(rem_fix);
      last_dot_q    <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dot_x_o       = dot_x_q;
  assign dot_y_o       = dot_y_q;
  assign byte_column_o = byte_column_q;
  assign bit_in_byte_o = bit_in_byte_q;
  assign last_dot_o    = last_dot_q;

  // Checks
  logic line_closed;
  logic err_in_range;
  assign line_closed  = !line_active_q && out_valid_q && last_dot_q;
  assign err_in_range = (error_acc_q >= ERR_MIN) && (error_acc_q <= ERR_MAX);

  `ASSERT_NEXT(a_load_arms_line, in_fire && is_load, line_active_q, "load did not arm line")
  `ASSERT_NEXT(a_last_ends_line, emit && is_last, line_closed, "last dot did not end line")
  `ASSERT_SAME(a_error_in_range, line_active_q, err_in_range, "error accumulator out of range")

endmodule
